[design/mfe_pkg.sv]
// mfe_pkg: shared types and constants of the max flow engine
// used by mfe_ctrl, mfe_dp and max_flow_engine; no dependencies
`default_nettype none

package mfe_pkg;

    localparam int NODES_DEF    = 16;
    localparam int CAP_BITS_DEF = 16;
    localparam int OP_W         = 2;
    localparam int NODE_W       = 4;
    localparam int ECAP_W       = 16;
    localparam int RESULT_W     = 20;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // datapath action for the current cycle
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LATCH,
        ACT_SWEEP_ALL,
        ACT_SWEEP_FLOW,
        ACT_MAT_AB,
        ACT_ADD_WR,
        ACT_RD_EVAL,
        ACT_BFS_INIT,
        ACT_DEQ,
        ACT_DEQ_TAKE,
        ACT_SCAN_EVAL,
        ACT_EDGE,
        ACT_A1_MIN,
        ACT_A2_FWD,
        ACT_A2_REV
    } act_t;

    typedef struct packed {
        act_t act;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic in_range;
        logic sweep_last;
        logic q_empty;
        logic hit;
        logic found;
        logic v_last;
        logic at_src;
    } dp_status_t;

endpackage

`default_nettype wire

[design/mfe_ram.sv]
// mfe_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module mfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/mfe_ctrl.sv]
// mfe_ctrl: sequencer of the max flow engine, drives mfe_dp by commands
// depends on mfe_pkg
`default_nettype none

module mfe_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire mfe_pkg::dp_status_t st,
    output mfe_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [22:0] {
        S_INIT  = 23'h000001,
        S_IDLE  = 23'h000002,
        S_DISP  = 23'h000004,
        S_CLR   = 23'h000008,
        S_FCLR  = 23'h000010,
        S_ADD_R = 23'h000020,
        S_ADD_W = 23'h000040,
        S_RD_R  = 23'h000080,
        S_RD_W  = 23'h000100,
        S_BFS   = 23'h000200,
        S_DEQ   = 23'h000400,
        S_DEQ_W = 23'h000800,
        S_SCAN  = 23'h001000,
        S_SCN_W = 23'h002000,
        S_A1_P  = 23'h004000,
        S_A1_PW = 23'h008000,
        S_A1_R  = 23'h010000,
        S_A2_P  = 23'h020000,
        S_A2_PW = 23'h040000,
        S_A2_F  = 23'h080000,
        S_A2_R  = 23'h100000,
        S_DONE  = 23'h200000,
        S_SPARE = 23'h400000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.act      = mfe_pkg::ACT_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.act = mfe_pkg::ACT_SWEEP_ALL;
                if (st.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.act    = mfe_pkg::ACT_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (st.op)
                    mfe_pkg::OP_CLEAR: state_next = S_CLR;
                    mfe_pkg::OP_ADD:   state_next = st.in_range ? S_ADD_R : S_DONE;
                    mfe_pkg::OP_RUN:   state_next = S_FCLR;
                    mfe_pkg::OP_READ:  state_next = S_RD_R;
                    default:           state_next = S_DONE;
                endcase
            end
            S_CLR:
            begin
                cmd.act = mfe_pkg::ACT_SWEEP_ALL;
                if (st.sweep_last)
                    state_next = S_DONE;
            end
            S_FCLR:
            begin
                cmd.act = mfe_pkg::ACT_SWEEP_FLOW;
                if (st.sweep_last)
                    state_next = st.in_range ? S_BFS : S_DONE;
            end
            S_ADD_R:
            begin
                cmd.act    = mfe_pkg::ACT_MAT_AB;
                state_next = S_ADD_W;
            end
            S_ADD_W:
            begin
                cmd.act    = mfe_pkg::ACT_ADD_WR;
                state_next = S_DONE;
            end
            S_RD_R:
            begin
                cmd.act    = mfe_pkg::ACT_MAT_AB;
                state_next = S_RD_W;
            end
            S_RD_W:
            begin
                cmd.act    = mfe_pkg::ACT_RD_EVAL;
                state_next = S_DONE;
            end
            S_BFS:
            begin
                cmd.act    = mfe_pkg::ACT_BFS_INIT;
                state_next = S_DEQ;
            end
            S_DEQ:
            begin
                cmd.act    = mfe_pkg::ACT_DEQ;
                state_next = st.q_empty ? S_DONE : S_DEQ_W;
            end
            S_DEQ_W:
            begin
                cmd.act    = mfe_pkg::ACT_DEQ_TAKE;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                state_next = S_SCN_W;
            end
            S_SCN_W:
            begin
                cmd.act = mfe_pkg::ACT_SCAN_EVAL;
                if (st.found)
                    state_next = S_A1_P;
                else if (st.v_last)
                    state_next = S_DEQ;
                else
                    state_next = S_SCAN;
            end
            S_A1_P:
            begin
                state_next = S_A1_PW;
            end
            S_A1_PW:
            begin
                cmd.act    = mfe_pkg::ACT_EDGE;
                state_next = S_A1_R;
            end
            S_A1_R:
            begin
                cmd.act    = mfe_pkg::ACT_A1_MIN;
                state_next = st.at_src ? S_A2_P : S_A1_P;
            end
            S_A2_P:
            begin
                state_next = S_A2_PW;
            end
            S_A2_PW:
            begin
                cmd.act    = mfe_pkg::ACT_EDGE;
                state_next = S_A2_F;
            end
            S_A2_F:
            begin
                cmd.act    = mfe_pkg::ACT_A2_FWD;
                state_next = S_A2_R;
            end
            S_A2_R:
            begin
                cmd.act    = mfe_pkg::ACT_A2_REV;
                state_next = st.at_src ? S_BFS : S_A2_P;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[design/mfe_dp.sv]
// mfe_dp: datapath of the max flow engine: matrices, search queue, parents, counters
// depends on mfe_pkg and mfe_ram
`default_nettype none

module mfe_dp #(
    parameter int NODES    = mfe_pkg::NODES_DEF,
    parameter int CAP_BITS = mfe_pkg::CAP_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mfe_pkg::ctrl_cmd_t           cmd,
    input  wire logic [mfe_pkg::OP_W-1:0]     operation,
    input  wire logic [mfe_pkg::NODE_W-1:0]   from_node,
    input  wire logic [mfe_pkg::NODE_W-1:0]   to_node,
    input  wire logic [mfe_pkg::ECAP_W-1:0]   edge_capacity,
    output mfe_pkg::dp_status_t               st,
    output logic      [mfe_pkg::RESULT_W-1:0] result_value
);

    localparam int NW    = $clog2(NODES);
    localparam int MW    = 2 * NW;
    localparam int FW    = CAP_BITS + 1;
    localparam int RW    = CAP_BITS + 1;
    localparam int SUMW  = ((CAP_BITS > mfe_pkg::ECAP_W) ? CAP_BITS : mfe_pkg::ECAP_W) + 1;
    localparam int WIDE  = ((CAP_BITS > mfe_pkg::RESULT_W) ? CAP_BITS : mfe_pkg::RESULT_W) + 2;
    localparam logic [SUMW-1:0] CAP_MAX = SUMW'((64'd1 << CAP_BITS) - 64'd1);
    localparam logic [WIDE-1:0] RES_MAX = WIDE'((64'd1 << mfe_pkg::RESULT_W) - 64'd1);

    mfe_pkg::op_t               op_reg;
    logic [NW-1:0]              a_reg, b_reg, u_reg, v_reg;
    logic [mfe_pkg::ECAP_W-1:0] cin_reg;
    logic                       inr_reg;
    logic [MW-1:0]              sweep_reg;
    logic [NW:0]                head_reg, tail_reg;
    logic [NODES-1:0]           vis_reg;
    logic [RW-1:0]              bn_reg;
    logic [mfe_pkg::RESULT_W-1:0] total_reg, res_reg, out_reg;

    logic                cap_we, flow_we, par_we, q_we;
    logic [MW-1:0]       cap_waddr, flow_waddr, mat_raddr;
    logic [CAP_BITS-1:0] cap_wdata, cap_rd;
    logic [FW-1:0]       flow_wdata, flow_rd;
    logic [NW-1:0]       par_rd, q_rd, q_waddr, q_wdata;

    logic signed [CAP_BITS+1:0] rsd;
    logic                       rsd_pos;
    logic [RW-1:0]              rsd_u;
    logic [SUMW-1:0]            add_sum;
    logic [WIDE-1:0]            tot_sum, rd_wide;
    logic [FW:0]                fwd_sum, rev_sum;
    logic                       in_range_now;

    mfe_ram #(.WIDTH(CAP_BITS), .DEPTH(2 ** MW)) u_cap_ram (
        .clk   (clk),
        .we    (cap_we),
        .waddr (cap_waddr),
        .wdata (cap_wdata),
        .raddr (mat_raddr),
        .rdata (cap_rd)
    );

    mfe_ram #(.WIDTH(FW), .DEPTH(2 ** MW)) u_flow_ram (
        .clk   (clk),
        .we    (flow_we),
        .waddr (flow_waddr),
        .wdata (flow_wdata),
        .raddr (mat_raddr),
        .rdata (flow_rd)
    );

    mfe_ram #(.WIDTH(NW), .DEPTH(NODES)) u_par_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (v_reg),
        .wdata (u_reg),
        .raddr (v_reg),
        .rdata (par_rd)
    );

    mfe_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg[NW-1:0]),
        .rdata (q_rd)
    );

    // residual of the edge just read
    assign rsd     = $signed({2'b00, cap_rd}) - $signed({flow_rd[FW-1], flow_rd});
    assign rsd_pos = !rsd[CAP_BITS+1] && (rsd != '0);
    assign rsd_u   = rsd[RW-1:0];

    assign add_sum = SUMW'(cap_rd) + SUMW'(cin_reg);
    assign tot_sum = WIDE'(total_reg) + WIDE'(bn_reg);
    assign rd_wide = WIDE'(flow_rd[FW-2:0]);
    assign fwd_sum = $signed({flow_rd[FW-1], flow_rd}) + $signed({1'b0, bn_reg});
    assign rev_sum = $signed({flow_rd[FW-1], flow_rd}) - $signed({1'b0, bn_reg});

    assign in_range_now = (32'(from_node) < 32'(NODES)) && (32'(to_node) < 32'(NODES));

    assign st.op         = op_reg;
    assign st.in_range   = inr_reg;
    assign st.sweep_last = &sweep_reg;
    assign st.q_empty    = (head_reg == tail_reg);
    assign st.hit        = !vis_reg[v_reg] && rsd_pos;
    assign st.found      = !vis_reg[v_reg] && rsd_pos && (v_reg == b_reg);
    assign st.v_last     = (v_reg == NW'(NODES - 1));
    assign st.at_src     = (u_reg == a_reg);

    assign result_value = out_reg;

    always_comb
    begin
        cap_we     = 1'b0;
        cap_waddr  = sweep_reg;
        cap_wdata  = '0;
        flow_we    = 1'b0;
        flow_waddr = sweep_reg;
        flow_wdata = '0;
        par_we     = 1'b0;
        q_we       = 1'b0;
        q_waddr    = tail_reg[NW-1:0];
        q_wdata    = v_reg;
        mat_raddr  = {u_reg, v_reg};
        case (cmd.act)
            mfe_pkg::ACT_SWEEP_ALL:
            begin
                cap_we  = 1'b1;
                flow_we = 1'b1;
            end
            mfe_pkg::ACT_SWEEP_FLOW:
            begin
                flow_we = 1'b1;
            end
            mfe_pkg::ACT_MAT_AB:
            begin
                mat_raddr = {a_reg, b_reg};
            end
            mfe_pkg::ACT_ADD_WR:
            begin
                cap_we    = 1'b1;
                cap_waddr = {a_reg, b_reg};
                cap_wdata = (add_sum > CAP_MAX) ? CAP_MAX[CAP_BITS-1:0]
                                                : add_sum[CAP_BITS-1:0];
            end
            mfe_pkg::ACT_BFS_INIT:
            begin
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = a_reg;
            end
            mfe_pkg::ACT_SCAN_EVAL:
            begin
                par_we = st.hit;
                q_we   = st.hit && !st.found && (tail_reg < (NW+1)'(NODES));
            end
            mfe_pkg::ACT_EDGE:
            begin
                mat_raddr = {par_rd, v_reg};
            end
            mfe_pkg::ACT_A2_FWD:
            begin
                flow_we    = 1'b1;
                flow_waddr = {u_reg, v_reg};
                flow_wdata = fwd_sum[FW-1:0];
                mat_raddr  = {v_reg, u_reg};
            end
            mfe_pkg::ACT_A2_REV:
            begin
                flow_we    = 1'b1;
                flow_waddr = {v_reg, u_reg};
                flow_wdata = rev_sum[FW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
            total_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            vis_reg   <= '0;
            op_reg    <= mfe_pkg::OP_CLEAR;
            inr_reg   <= 1'b0;
        end
        else
        begin
            case (cmd.act)
                mfe_pkg::ACT_LATCH:
                begin
                    op_reg  <= mfe_pkg::op_t'(operation);
                    inr_reg <= in_range_now;
                end
                mfe_pkg::ACT_SWEEP_ALL, mfe_pkg::ACT_SWEEP_FLOW:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    total_reg <= '0;
                end
                mfe_pkg::ACT_BFS_INIT:
                begin
                    vis_reg  <= NODES'(1) << a_reg;
                    head_reg <= '0;
                    tail_reg <= (NW+1)'(1);
                end
                mfe_pkg::ACT_DEQ:
                begin
                    if (head_reg != tail_reg)
                        head_reg <= head_reg + 1'b1;
                end
                mfe_pkg::ACT_SCAN_EVAL:
                begin
                    if (st.hit)
                    begin
                        vis_reg[v_reg] <= 1'b1;
                        if (!st.found && (tail_reg < (NW+1)'(NODES)))
                            tail_reg <= tail_reg + 1'b1;
                    end
                end
                mfe_pkg::ACT_A2_REV:
                begin
                    if (st.at_src)
                        total_reg <= (tot_sum > RES_MAX) ? RES_MAX[mfe_pkg::RESULT_W-1:0]
                                                         : tot_sum[mfe_pkg::RESULT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_reg <= res_reg;
        case (cmd.act)
            mfe_pkg::ACT_LATCH:
            begin
                a_reg   <= NW'(from_node);
                b_reg   <= NW'(to_node);
                cin_reg <= edge_capacity;
                res_reg <= '0;
            end
            mfe_pkg::ACT_RD_EVAL:
            begin
                if (inr_reg && !flow_rd[FW-1] && (flow_rd != '0))
                    res_reg <= (rd_wide > RES_MAX) ? RES_MAX[mfe_pkg::RESULT_W-1:0]
                                                   : rd_wide[mfe_pkg::RESULT_W-1:0];
            end
            mfe_pkg::ACT_DEQ:
            begin
                if (head_reg == tail_reg)
                    res_reg <= total_reg;
            end
            mfe_pkg::ACT_DEQ_TAKE:
            begin
                u_reg <= q_rd;
                v_reg <= '0;
            end
            mfe_pkg::ACT_SCAN_EVAL:
            begin
                if (st.found)
                    bn_reg <= '1;
                else
                    v_reg <= v_reg + 1'b1;
            end
            mfe_pkg::ACT_EDGE:
            begin
                u_reg <= par_rd;
            end
            mfe_pkg::ACT_A1_MIN:
            begin
                if (rsd_u < bn_reg)
                    bn_reg <= rsd_u;
                v_reg <= st.at_src ? b_reg : u_reg;
            end
            mfe_pkg::ACT_A2_REV:
            begin
                v_reg <= u_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

[design/max_flow_engine.sv]
// max_flow_engine: edmonds-karp maximum flow over a capacity matrix
// depends on mfe_pkg, mfe_ctrl, mfe_dp (which uses mfe_ram)
//
// usage: one command per input transfer (operation, from_node, to_node,
// edge_capacity), one result_value per command on the output channel.
// operations: clear graph, add edge capacity (saturating), run max flow
// from source from_node to sink to_node (result: total flow), read net
// flow on one edge.
// steps: clear sweeps both matrices to zero; add and read each read the
// matrix entry, then write or evaluate it; run first sweeps the flow
// matrix to zero, then per augmenting round does one breadth-first search
// over the matrix entries, then walks the path back twice (bottleneck,
// then flow update); the registered matrix ram read paces each step.
// one command is in work at a time; in_ready is high only while idle.
// after reset a sweep zeroes the matrices before the first input transfer
// is taken.
// when the receiver stalls the finished result is held in the output
// register; the next command is accepted meanwhile and its result waits
// until the held one is taken.
`default_nettype none

module max_flow_engine #(
    parameter int NODES    = mfe_pkg::NODES_DEF,
    parameter int CAP_BITS = mfe_pkg::CAP_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [mfe_pkg::OP_W-1:0]     operation,
    input  wire logic [mfe_pkg::NODE_W-1:0]   from_node,
    input  wire logic [mfe_pkg::NODE_W-1:0]   to_node,
    input  wire logic [mfe_pkg::ECAP_W-1:0]   edge_capacity,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [mfe_pkg::RESULT_W-1:0] result_value
);

    mfe_pkg::ctrl_cmd_t  cmd;
    mfe_pkg::dp_status_t st;

    mfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    mfe_dp #(.NODES(NODES), .CAP_BITS(CAP_BITS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .operation     (operation),
        .from_node     (from_node),
        .to_node       (to_node),
        .edge_capacity (edge_capacity),
        .st            (st),
        .result_value  (result_value)
    );

endmodule

`default_nettype wire
